>>> rtl/vsp_pkg.sv
// vsp_pkg: widths, pixel type and submode codes of the 4x4 subblock predictor
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package vsp_pkg;

  localparam int PIX_W  = 8;
  localparam int MODE_W = 4;
  localparam int ROW_W  = 4 * PIX_W;

  typedef logic [PIX_W-1:0] pix_t;

  localparam logic [MODE_W-1:0] MODE_DC = 4'd0;
  localparam logic [MODE_W-1:0] MODE_TM = 4'd1;
  localparam logic [MODE_W-1:0] MODE_VE = 4'd2;
  localparam logic [MODE_W-1:0] MODE_HE = 4'd3;
  localparam logic [MODE_W-1:0] MODE_LD = 4'd4;
  localparam logic [MODE_W-1:0] MODE_RD = 4'd5;
  localparam logic [MODE_W-1:0] MODE_VR = 4'd6;
  localparam logic [MODE_W-1:0] MODE_VL = 4'd7;
  localparam logic [MODE_W-1:0] MODE_HD = 4'd8;
  localparam logic [MODE_W-1:0] MODE_HU = 4'd9;

endpackage

`default_nettype wire

>>> rtl/vsp_req_if.sv
// vsp_req_if: request channel of the subblock predictor (valid/ready + edge pixels)
// depends on vsp_pkg
`default_nettype none

interface vsp_req_if import vsp_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  pix_t              corner;
  logic [ROW_W-1:0]  above_row;
  logic [ROW_W-1:0]  above_right;
  logic [ROW_W-1:0]  left_col;

  modport source (
    output valid, mode, corner, above_row, above_right, left_col,
    input  ready
  );

  modport sink (
    input  valid, mode, corner, above_row, above_right, left_col,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/vsp_res_if.sv
// vsp_res_if: result channel of the subblock predictor (valid/ready + four rows)
// depends on vsp_pkg
`default_nettype none

interface vsp_res_if import vsp_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_zero;
  logic [ROW_W-1:0] row_one;
  logic [ROW_W-1:0] row_two;
  logic [ROW_W-1:0] row_three;
  logic             bad_mode;

  modport source (
    output valid, row_zero, row_one, row_two, row_three, bad_mode,
    input  ready
  );

  modport sink (
    input  valid, row_zero, row_one, row_two, row_three, bad_mode,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/vp8_subblock_intra_predict_top.sv
// VP8 4x4 luma subblock intra predictor. A request carries the submode, the
// corner pixel and the above, above-right and left edges; the result is the
// sixteen predicted pixels as four packed rows plus a bad_mode flag (rows
// zero) for the six undefined submodes. The block is a three-stage pipeline:
// the edge line is registered, then all two-tap and three-tap averages, the
// DC sum and the true-motion differences are formed, then the submode picks
// each pixel and the true-motion sums are clamped into the output register.
// One request is taken every cycle while ready is high; ready falls
// only when all three stages hold requests and the result side is stalled.
// Depends on vsp_pkg, vsp_req_if and vsp_res_if.
`default_nettype none

module vp8_subblock_intra_predict_top import vsp_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  vsp_req_if.sink     req,
  vsp_res_if.source   res
);

  function automatic pix_t avg2(input pix_t a, input pix_t b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
    return s[PIX_W:1];
  endfunction

  function automatic pix_t avg3(input pix_t a, input pix_t b, input pix_t c);
    logic [PIX_W+1:0] s;
    s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + {{PIX_W{1'b0}}, 2'b10};
    return s[PIX_W+1:2];
  endfunction

  // stage enables
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3 = !v3 || res.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;

  // stage 1: edge line, L3..L0, corner, A0..A3, X0..X3, X3 repeated
  pix_t              t1 [0:13];
  logic [MODE_W-1:0] mode1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req.valid;
    end
    if (en1 && req.valid) begin
      mode1 <= req.mode;
      for (int k = 0; k < 4; k++) begin
        t1[3-k] <= req.left_col[PIX_W*k +: PIX_W];
        t1[5+k] <= req.above_row[PIX_W*k +: PIX_W];
        t1[9+k] <= req.above_right[PIX_W*k +: PIX_W];
      end
      t1[4]  <= req.corner;
      t1[13] <= req.above_right[PIX_W*3 +: PIX_W];
    end
  end

  // stage 2: averages, dc value, true-motion differences
  logic [PIX_W+2:0] dc_sum;

  always_comb begin
    dc_sum = 11'd4;
    for (int k = 0; k < 4; k++) begin
      dc_sum = dc_sum + {3'b000, t1[k]} + {3'b000, t1[5+k]};
    end
  end

  pix_t               m2_2 [0:8];
  pix_t               m3_2 [1:12];
  pix_t               low2;
  pix_t               dc2;
  logic signed [PIX_W+1:0] amc2 [0:3];
  pix_t               lft2 [0:3];
  logic [MODE_W-1:0]  mode2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2 && v1) begin
      mode2 <= mode1;
      for (int i = 0; i <= 8; i++) begin
        m2_2[i] <= avg2(t1[i], t1[i+1]);
      end
      for (int i = 1; i <= 12; i++) begin
        m3_2[i] <= avg3(t1[i-1], t1[i], t1[i+1]);
      end
      low2 <= avg3(t1[1], t1[0], t1[0]);
      dc2  <= dc_sum[PIX_W+2:3];
      for (int k = 0; k < 4; k++) begin
        amc2[k] <= $signed({2'b00, t1[5+k]}) - $signed({2'b00, t1[4]});
        lft2[k] <= t1[3-k];
      end
    end
  end

  // stage 3: submode selection and clamping
  pix_t                    p [0:3][0:3];
  logic                    bad;
  logic signed [PIX_W+1:0] tm;

  always_comb begin
    bad = 1'b0;
    tm  = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        p[r][c] = '0;
      end
    end
    case (mode2)
      MODE_DC: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            p[r][c] = dc2;
          end
        end
      end
      MODE_TM: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            tm = amc2[c] + $signed({2'b00, lft2[r]});
            if (tm < 0) begin
              p[r][c] = '0;
            end else if (tm > 255) begin
              p[r][c] = '1;
            end else begin
              p[r][c] = tm[PIX_W-1:0];
            end
          end
        end
      end
      MODE_VE: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            p[r][c] = m3_2[5+c];
          end
        end
      end
      MODE_HE: begin
        for (int c = 0; c < 4; c++) begin
          p[0][c] = m3_2[3];
          p[1][c] = m3_2[2];
          p[2][c] = m3_2[1];
          p[3][c] = low2;
        end
      end
      MODE_LD: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            p[r][c] = m3_2[6+r+c];
          end
        end
      end
      MODE_RD: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            p[r][c] = m3_2[4-r+c];
          end
        end
      end
      MODE_VR: begin
        p[3][0] = m3_2[2];
        p[2][0] = m3_2[3];
        p[3][1] = m3_2[4];
        p[1][0] = m3_2[4];
        p[2][1] = m2_2[4];
        p[0][0] = m2_2[4];
        p[3][2] = m3_2[5];
        p[1][1] = m3_2[5];
        p[2][2] = m2_2[5];
        p[0][1] = m2_2[5];
        p[3][3] = m3_2[6];
        p[1][2] = m3_2[6];
        p[2][3] = m2_2[6];
        p[0][2] = m2_2[6];
        p[1][3] = m3_2[7];
        p[0][3] = m2_2[7];
      end
      MODE_VL: begin
        p[0][0] = m2_2[5];
        p[1][0] = m3_2[6];
        p[2][0] = m2_2[6];
        p[0][1] = m2_2[6];
        p[1][1] = m3_2[7];
        p[3][0] = m3_2[7];
        p[2][1] = m2_2[7];
        p[0][2] = m2_2[7];
        p[3][1] = m3_2[8];
        p[1][2] = m3_2[8];
        p[2][2] = m2_2[8];
        p[0][3] = m2_2[8];
        p[3][2] = m3_2[9];
        p[1][3] = m3_2[9];
        p[2][3] = m3_2[10];
        p[3][3] = m3_2[11];
      end
      MODE_HD: begin
        p[3][0] = m2_2[0];
        p[3][1] = m3_2[1];
        p[2][0] = m2_2[1];
        p[3][2] = m2_2[1];
        p[2][1] = m3_2[2];
        p[3][3] = m3_2[2];
        p[2][2] = m2_2[2];
        p[1][0] = m2_2[2];
        p[2][3] = m3_2[3];
        p[1][1] = m3_2[3];
        p[1][2] = m2_2[3];
        p[0][0] = m2_2[3];
        p[1][3] = m3_2[4];
        p[0][1] = m3_2[4];
        p[0][2] = m3_2[5];
        p[0][3] = m3_2[6];
      end
      MODE_HU: begin
        p[0][0] = m2_2[2];
        p[0][1] = m3_2[2];
        p[0][2] = m2_2[1];
        p[1][0] = m2_2[1];
        p[0][3] = m3_2[1];
        p[1][1] = m3_2[1];
        p[1][2] = m2_2[0];
        p[2][0] = m2_2[0];
        p[1][3] = low2;
        p[2][1] = low2;
        p[2][2] = lft2[3];
        p[2][3] = lft2[3];
        for (int c = 0; c < 4; c++) begin
          p[3][c] = lft2[3];
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3 && v2) begin
      res.row_zero  <= {p[0][3], p[0][2], p[0][1], p[0][0]};
      res.row_one   <= {p[1][3], p[1][2], p[1][1], p[1][0]};
      res.row_two   <= {p[2][3], p[2][2], p[2][1], p[2][0]};
      res.row_three <= {p[3][3], p[3][2], p[3][1], p[3][0]};
      res.bad_mode  <= bad;
    end
  end

  assign res.valid = v3;

`ifndef ASSERT_OFF
  a_req_enters: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> v1)
    else $error("accepted request missing from first stage");

  a_mid_advances: assert property (@(posedge clk) disable iff (rst)
    v2 && en3 |=> res.valid)
    else $error("second stage request lost on its way to the output");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.bad_mode |->
      res.row_zero == '0 && res.row_one == '0 &&
      res.row_two == '0 && res.row_three == '0)
    else $error("undefined submode gave non-zero pixels");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> v1 && v2 && v3 && !res.ready)
    else $error("request side stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire
